### hdl/gmt_pkg.sv
// Package with the slot record type and command and register codes of the membership table.
package gmt_pkg;

  // Command codes carried by an input transaction.
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_JOIN   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SELF_ID        = 3'd0;
  localparam logic [2:0] REG_SELF_PORT      = 3'd1;
  localparam logic [2:0] REG_PING_PERIOD    = 3'd2;
  localparam logic [2:0] REG_FAIL_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_REMOVE_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_START_IN_GROUP = 3'd5;

  localparam logic [30:0] HB_MAX = 31'h7FFF_FFFF;

  // Contents of one table slot.
  typedef struct packed {
    logic        valid;
    logic        failed;
    logic [31:0] id;
    logic [15:0] port;
    logic [30:0] heartbeat;
    logic [31:0] stamp;
  } slot_t;

endpackage

### hdl/gmt_cell.sv
// One cell of the slot ring: holds one slot and takes its neighbour's slot on a shift.
module gmt_cell
  import gmt_pkg::*;
#(
  parameter bit RESET_VALID = 1'b0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  logic        valid_q;
  logic        failed_q;
  logic [30:0] heartbeat_q;
  logic [31:0] stamp_q;
  logic [31:0] id_q;
  logic [15:0] port_q;

  // Control and reset-defined fields are reset (valid to RESET_VALID, the rest cleared); address fields need no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= RESET_VALID;
      failed_q    <= 1'b0;
      heartbeat_q <= '0;
      stamp_q     <= '0;
    end else if (shift_i) begin
      valid_q     <= slot_i.valid;
      failed_q    <= slot_i.failed;
      heartbeat_q <= slot_i.heartbeat;
      stamp_q     <= slot_i.stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q   <= slot_i.id;
      port_q <= slot_i.port;
    end
  end

  assign slot_o = {valid_q, failed_q, id_q, port_q, heartbeat_q, stamp_q};

endmodule

### hdl/gossip_membership_table.sv
// Top level of the gossip heartbeat membership table with its ring of slot cells.
// Each pass turns the table once through a single processing point at the ring head, one slot a cycle.
// An update runs a search rotation, followed by an insertion rotation when a new member is inserted;
// an update for a member matching the own address runs no rotation and leaves the block idle.
// A tick in group runs an ageing rotation, which disseminates when the ping countdown has run out and
// is then followed by a flush state; out of group a tick only advances the time. During a dissemination
// one result appears per valid slot on the entry ports, each for a single cycle marked by
// entry_valid_o; the receiver must take it then, as results cannot be held off. start is
// taken only while busy is low, and configuration writes are taken only while idle.
module gossip_membership_table
  import gmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] member_id_i,
  input  logic [15:0] member_port_i,
  input  logic signed [31:0] member_heartbeat_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        entry_valid_o,
  output logic [31:0] entry_id_o,
  output logic [15:0] entry_port_o,
  output logic signed [31:0] entry_heartbeat_o,
  output logic        last_o
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_INSERT = 3'd2;
  localparam logic [2:0] ST_TICK   = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [IDXW-1:0] cnt_q, cnt_d;

  logic [31:0] self_id_q;
  logic [15:0] self_port_q;
  logic [7:0]  ping_period_q;
  logic [15:0] fail_timeout_q, remove_timeout_q;
  logic        in_group_q, in_group_d;
  logic [7:0]  countdown_q, countdown_d;
  logic [31:0] time_q, time_d;

  logic [31:0] mid_q, mid_d;
  logic [15:0] mport_q, mport_d;
  logic [30:0] mhb_q, mhb_d;
  logic        frep_q, frep_d;
  logic        matched_q, matched_d;
  logic        free_found_q, free_found_d;
  logic [IDXW-1:0] free_idx_q, free_idx_d;
  logic        emit_q, emit_d;

  slot_t pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_id_q, out_id_d;
  logic [15:0] out_port_q, out_port_d;
  logic [31:0] out_hb_q, out_hb_d;
  logic        out_last_q, out_last_d;

  slot_t cell_q [TABLE_ENTRIES];
  slot_t proc;
  logic  shift;
  logic  accept;
  logic  cfg_we;
  logic [31:0] age;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign shift       = (state_q == ST_SCAN) || (state_q == ST_INSERT) || (state_q == ST_TICK);
  assign age         = time_q - cell_q[0].stamp;

  // Ring of cells: each cell takes its upper neighbour, the last takes the processed head.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    slot_t nxt;
    if (k == TABLE_ENTRIES - 1) begin : g_wrap
      assign nxt = proc;
    end else begin : g_link
      assign nxt = cell_q[k+1];
    end
    gmt_cell #(
      .RESET_VALID(k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (nxt),
      .slot_o (cell_q[k])
    );
  end

  // Sequencer and the processing point at the ring head.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    in_group_d   = in_group_q;
    countdown_d  = countdown_q;
    time_d       = time_q;
    mid_d        = mid_q;
    mport_d      = mport_q;
    mhb_d        = mhb_q;
    frep_d       = frep_q;
    matched_d    = matched_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    emit_d       = emit_q;
    pend_d       = pend_q;
    proc         = cell_q[0];
    out_valid_d  = 1'b0;
    out_id_d     = out_id_q;
    out_port_d   = out_port_q;
    out_hb_d     = out_hb_q;
    out_last_d   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mid_d        = member_id_i;
          mport_d      = member_port_i;
          mhb_d        = member_heartbeat_i[31] ? '0 : member_heartbeat_i[30:0];
          frep_d       = (member_heartbeat_i == -32'sd1);
          matched_d    = 1'b0;
          free_found_d = 1'b0;
          cnt_d        = '0;
          case (cmd_i)
            CMD_UPDATE, CMD_JOIN: begin
              if (cmd_i == CMD_JOIN) begin
                in_group_d = 1'b1;
              end
              if (!(member_id_i == self_id_q && member_port_i == self_port_q)) begin
                state_d = ST_SCAN;
              end
            end
            CMD_TICK: begin
              if (in_group_q) begin
                emit_d  = (countdown_q == '0);
                countdown_d = (countdown_q == '0) ? ping_period_q : countdown_q - 8'd1;
                pend_d.valid = 1'b0;
                state_d = ST_TICK;
              end else begin
                time_d = time_q + 32'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Search pass: refresh or fail a matching entry and note the lowest free slot.
      ST_SCAN: begin
        if (cnt_q != '0) begin
          if (cell_q[0].valid && cell_q[0].id == mid_q && cell_q[0].port == mport_q
              && !matched_q) begin
            matched_d = 1'b1;
            if (frep_q) begin
              proc.failed = 1'b1;
            end else if (!cell_q[0].failed && cell_q[0].heartbeat < mhb_q) begin
              proc.heartbeat = mhb_q;
              proc.stamp     = time_q;
            end
          end
          if (!cell_q[0].valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cnt_q;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d = '0;
          if (!matched_d && !frep_q && free_found_d) begin
            state_d = ST_INSERT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // Insertion pass: write the new member as its slot passes the head.
      ST_INSERT: begin
        if (cnt_q == free_idx_q) begin
          proc.valid     = 1'b1;
          proc.failed    = 1'b0;
          proc.id        = mid_q;
          proc.port      = mport_q;
          proc.heartbeat = mhb_q;
          proc.stamp     = time_q;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end

      // Tick pass: when dissemination is due, emit with one entry held back for the last flag; then age.
      ST_TICK: begin
        if (emit_q) begin
          if (cnt_q == '0) begin
            proc.heartbeat = (cell_q[0].heartbeat < HB_MAX) ?
                             cell_q[0].heartbeat + 31'd1 : cell_q[0].heartbeat;
            proc.stamp     = time_q;
            proc.id        = self_id_q;
            proc.port      = self_port_q;
          end
          if (cell_q[0].valid) begin
            if (pend_q.valid) begin
              out_valid_d = 1'b1;
              out_id_d    = pend_q.id;
              out_port_d  = pend_q.port;
              out_hb_d    = pend_q.failed ? 32'hFFFF_FFFF : {1'b0, pend_q.heartbeat};
            end
            pend_d = proc;
          end
        end
        if (cnt_q != '0 && cell_q[0].valid) begin
          if (age > {16'd0, remove_timeout_q}) begin
            proc.valid = 1'b0;
          end else if (age > {16'd0, fail_timeout_q}) begin
            proc.failed = 1'b1;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          time_d  = time_q + 32'd1;
          state_d = emit_q ? ST_FLUSH : ST_IDLE;
        end
      end

      ST_FLUSH: begin
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        out_id_d    = pend_q.id;
        out_port_d  = pend_q.port;
        out_hb_d    = pend_q.failed ? 32'hFFFF_FFFF : {1'b0, pend_q.heartbeat};
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Configuration writes side-load the countdown and the group flag.
    if (cfg_we && cfg_index_i == REG_PING_PERIOD) begin
      countdown_d = cfg_data_i[7:0];
    end
    if (cfg_we && cfg_index_i == REG_START_IN_GROUP) begin
      in_group_d = cfg_data_i[0];
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cnt_q            <= '0;
      self_id_q        <= '0;
      self_port_q      <= '0;
      ping_period_q    <= 8'd2;
      fail_timeout_q   <= 16'd5;
      remove_timeout_q <= 16'd20;
      in_group_q       <= 1'b0;
      countdown_q      <= 8'd2;
      time_q           <= '0;
      matched_q        <= 1'b0;
      free_found_q     <= 1'b0;
      emit_q           <= 1'b0;
      pend_q           <= '0;
      out_valid_q      <= 1'b0;
      out_last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      in_group_q   <= in_group_d;
      countdown_q  <= countdown_d;
      time_q       <= time_d;
      matched_q    <= matched_d;
      free_found_q <= free_found_d;
      emit_q       <= emit_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      if (cfg_we) begin
        case (cfg_index_i)
          REG_SELF_ID:        self_id_q        <= cfg_data_i;
          REG_SELF_PORT:      self_port_q      <= cfg_data_i[15:0];
          REG_PING_PERIOD:    ping_period_q    <= cfg_data_i[7:0];
          REG_FAIL_TIMEOUT:   fail_timeout_q   <= cfg_data_i[15:0];
          REG_REMOVE_TIMEOUT: remove_timeout_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mid_q            <= mid_d;
    mport_q          <= mport_d;
    mhb_q            <= mhb_d;
    frep_q           <= frep_d;
    free_idx_q       <= free_idx_d;
    out_id_q         <= out_id_d;
    out_port_q       <= out_port_d;
    out_hb_q         <= out_hb_d;
  end

  assign entry_valid_o     = out_valid_q;
  assign entry_id_o        = out_id_q;
  assign entry_port_o      = out_port_q;
  assign entry_heartbeat_o = out_hb_q;
  assign last_o            = out_last_q;

endmodule
